/* rtl/ard_pkg.sv */
`timescale 1ns / 1ps
package ard_pkg;

  typedef enum logic [1:0] {
    CMD_ACCESS = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_SEGMENT   = 3'd0,
    ST_FAULT     = 3'd1,
    ST_ADDED     = 3'd2,
    ST_REJECTED  = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_e;

  // Query travelling down the chain of region cells.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [32:0] cur;     // access cursor, or base for add and remove
    logic [32:0] qend;    // end of the region being added
    logic        hit;     // an earlier cell matched (access or remove)
    logic        overlap; // an earlier cell overlaps the new region
    logic        slot;    // an earlier free cell has claimed the add
    logic [3:0]  dev;
    logic [32:0] seg_end; // end of the matched region
    logic [31:0] off;     // device offset of the matched region at cur
  } query_t;

  // Data handed to a cell on a successful add.
  typedef struct packed {
    logic [31:0] base;
    logic [32:0] rend;
    logic [3:0]  dev;
    logic [31:0] off;
  } region_t;

endpackage

/* rtl/ard_cell.sv */
`timescale 1ns / 1ps
module ard_cell import ard_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  logic    commit_i,
  input  region_t region_i,
  input  query_t  q_i,
  output query_t  q_o
);

  logic        valid_q, valid_d;
  logic [31:0] base_q;
  logic [32:0] end_q;
  logic [3:0]  dev_q;
  logic [31:0] off_q;
  query_t      q_d, q_q;
  logic        claim;

  always_comb begin
    q_d     = q_i;
    valid_d = valid_q;
    claim   = 1'b0;
    unique case (q_i.cmd)
      CMD_ACCESS: begin
        if (!q_i.hit && valid_q && {1'b0, base_q} <= q_i.cur && q_i.cur < end_q) begin
          q_d.hit     = 1'b1;
          q_d.dev     = dev_q;
          q_d.seg_end = end_q;
          q_d.off     = q_i.cur[31:0] - base_q + off_q;
        end
      end
      CMD_ADD: begin
        if (valid_q) begin
          if ({1'b0, base_q} < q_i.qend && q_i.cur < end_q) q_d.overlap = 1'b1;
        end else if (!q_i.slot) begin
          q_d.slot = 1'b1;
          claim    = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (!q_i.hit && valid_q && base_q == q_i.cur[31:0]) begin
          q_d.hit = 1'b1;
          if (step_i) valid_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // The claiming cell of an add remembers its claim until the verdict arrives.
  // Only an add request passing through the cell, or a commit, updates the claim.
  logic pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      if (step_i) begin
        valid_q <= valid_d;
        if (q_i.cmd == CMD_ADD) pend_q <= claim;
      end else if (commit_i && pend_q) begin
        valid_q <= 1'b1;
        pend_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) q_q <= q_d;
    if (commit_i && pend_q && !step_i) begin
      base_q <= region_i.base;
      end_q  <= region_i.rend;
      dev_q  <= region_i.dev;
      off_q  <= region_i.off;
    end
  end

  assign q_o = q_q;

endmodule

/* rtl/address_region_decoder.sv */
`timescale 1ns / 1ps
// Bus address decoder over a table of MAX_REGIONS regions held in a chain of
// cells, one region per cell. A request enters the head of the chain and moves
// one cell per cycle; each cell compares it with its own region and passes the
// query, with what it learned, to the next. An add or remove request makes one
// pass through the chain, and its result is loaded into the output register
// when the pass reaches the tail. An access makes one pass for each segment;
// a pass that finds no region yields the fault for a gap or for a range past
// 2^32. After MAX_REGIONS segments, a range that is still not covered faults,
// and an empty or oversized access skips the chain and goes to the fault.
// While the output register holds a result that has not been accepted, the
// finished pass waits at the tail of the chain. Requests are handled one at a
// time; the block is ready for the next request in the cycle after the last
// result of the current one has been loaded into the output register.
module address_region_decoder import ard_pkg::*; #(
  parameter int MAX_REGIONS      = 8,
  parameter int NUM_DEVICES      = 16,
  parameter int MAX_ACCESS_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] address_i,
  input  logic [12:0] access_size_i,
  input  logic        write_not_read_i,
  input  logic [31:0] region_size_i,
  input  logic [3:0]  device_number_i,
  input  logic [31:0] device_base_offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [3:0]  target_device_o,
  output logic [31:0] target_offset_o,
  output logic [12:0] segment_length_o,
  output logic        direction_o,
  output logic        last_o
);

  localparam int CW = $clog2(MAX_REGIONS + 2);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_EMIT = 4'b0100,
    S_WAIT = 4'b1000
  } state_e;

  state_e       state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [32:0]  cur_q, cur_d, stop_q, end_q;
  logic [1:0]   cmd_q;
  logic         dir_q;
  logic [CW-1:0] nseg_q, nseg_d;
  region_t      reg_q;
  logic         reject_q;

  query_t q [MAX_REGIONS+1];
  query_t head;
  logic   step, commit;

  always_comb begin
    head      = '0;
    head.cmd  = (state_q == S_RUN && cnt_q == '0) ? cmd_q : CMD_UNUSED;
    head.cur  = cur_q;
    head.qend = end_q;
  end

  assign q[0] = head;

  // The chain holds still while the query sits at its tail, so a stalled
  // output keeps the verdict and the claim of an add intact.
  assign step = (state_q == S_RUN) && (cnt_q != CW'(MAX_REGIONS));

  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    ard_cell u_cell (
      .clk_i, .rst_ni,
      .step_i  (step),
      .commit_i(commit),
      .region_i(reg_q),
      .q_i     (q[i]),
      .q_o     (q[i+1])
    );
  end

  query_t tail;
  assign tail = q[MAX_REGIONS];

  logic        ov_valid_q;
  logic [2:0]  ov_st_q;
  logic [3:0]  ov_dev_q;
  logic [31:0] ov_off_q;
  logic [12:0] ov_len_q;
  logic        ov_dir_q, ov_last_q;

  logic        load;
  logic [2:0]  n_st;
  logic [3:0]  n_dev;
  logic [31:0] n_off;
  logic [12:0] n_len;
  logic        n_dir, n_last;
  logic [32:0] seg_end;

  assign in_ready_o = (state_q == S_IDLE);
  assign seg_end    = (tail.seg_end < stop_q) ? tail.seg_end : stop_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cur_d   = cur_q;
    nseg_d  = nseg_q;
    load    = 1'b0;
    commit  = 1'b0;
    n_st = ST_SEGMENT; n_dev = '0; n_off = '0; n_len = '0; n_dir = 1'b0; n_last = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cnt_d   = '0;
          nseg_d  = '0;
          cur_d   = (command_i == CMD_ACCESS) ? {1'b0, address_i} : {1'b0, address_i};
          if (command_i == CMD_UNUSED) state_d = S_IDLE;
          else if (command_i == CMD_ACCESS &&
                   (access_size_i == '0 || 32'(access_size_i) > MAX_ACCESS_BYTES))
            state_d = S_EMIT;
          else state_d = S_RUN;
        end
      end
      S_RUN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(MAX_REGIONS)) begin
          if (!ov_valid_q || out_ready_i) begin
            load  = 1'b1;
            cnt_d = '0;
            unique case (cmd_q)
              CMD_ADD: begin
                n_last = 1'b1;
                if (reject_q || tail.overlap || !tail.slot) n_st = ST_REJECTED;
                else begin
                  n_st   = ST_ADDED;
                  commit = 1'b1;
                end
                state_d = S_IDLE;
              end
              CMD_REMOVE: begin
                n_last  = 1'b1;
                n_st    = tail.hit ? ST_REMOVED : ST_NOT_FOUND;
                state_d = S_IDLE;
              end
              default: begin
                n_dir = dir_q;
                if (tail.hit) begin
                  n_dev  = tail.dev;
                  n_off  = tail.off;
                  n_len  = 13'(seg_end - cur_q);
                  cur_d  = seg_end;
                  nseg_d = nseg_q + 1'b1;
                  if (seg_end == stop_q) begin
                    n_last  = 1'b1;
                    state_d = S_IDLE;
                  end else if (32'(nseg_q) + 1 == MAX_REGIONS) begin
                    state_d = S_EMIT;
                  end
                end else begin
                  n_st    = ST_FAULT;
                  n_off   = cur_q[31:0];
                  n_last  = 1'b1;
                  state_d = S_IDLE;
                end
              end
            endcase
          end else begin
            cnt_d = cnt_q;
          end
        end
      end
      S_EMIT: begin
        if (!ov_valid_q || out_ready_i) begin
          load    = 1'b1;
          n_st    = ST_FAULT;
          n_off   = cur_q[31:0];
          n_dir   = dir_q;
          n_last  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commit writes the cells on the cycle the add leaves S_RUN; step is then low.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      ov_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load) ov_valid_q <= 1'b1;
      else if (out_ready_i) ov_valid_q <= 1'b0;
    end
  end

  // The cell write happens while state is leaving S_RUN; hold step low there.
  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    nseg_q <= nseg_d;
    if (in_valid_i && in_ready_o) begin
      cmd_q    <= command_i;
      dir_q    <= write_not_read_i;
      stop_q   <= {1'b0, address_i} + 33'(access_size_i);
      end_q    <= ({1'b0, address_i} + {1'b0, region_size_i} > 33'h1_0000_0000) ?
                  33'h1_0000_0000 : {1'b0, address_i} + {1'b0, region_size_i};
      reject_q <= (region_size_i == '0) || (32'(device_number_i) >= NUM_DEVICES);
      reg_q.base <= address_i;
      reg_q.rend <= ({1'b0, address_i} + {1'b0, region_size_i} > 33'h1_0000_0000) ?
                    33'h1_0000_0000 : {1'b0, address_i} + {1'b0, region_size_i};
      reg_q.dev  <= device_number_i;
      reg_q.off  <= device_base_offset_i;
    end
    if (load) begin
      ov_st_q   <= n_st;
      ov_dev_q  <= n_dev;
      ov_off_q  <= n_off;
      ov_len_q  <= n_len;
      ov_dir_q  <= n_dir;
      ov_last_q <= n_last;
    end
  end

  assign out_valid_o      = ov_valid_q;
  assign status_o         = ov_st_q;
  assign target_device_o  = ov_dev_q;
  assign target_offset_o  = ov_off_q;
  assign segment_length_o = ov_len_q;
  assign direction_o      = ov_dir_q;
  assign last_o           = ov_last_q;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for the address region decoder. A queue of requests is
// filled up front: a short directed part that walks the edge cases, then
// random traffic that builds regions inside a small address window so that
// accesses cross several regions and gaps. A clocked driver presents requests
// at the falling edge and a clocked monitor samples the result channel at the
// rising edge, where each accepted request is also run through a local copy
// of the region table to queue the results it should produce.
module testbench;
  import ard_pkg::*;

  localparam int REGIONS    = 8;
  localparam int DEVICES    = 16;
  localparam int MAX_BYTES  = 4096;
  localparam int CYCLE_CAP  = 400000;
  localparam int CALM_ITEMS = 25;

  // One bus request as it is offered to the block. The command is kept as a
  // plain vector because the unused value is also sent.
  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] addr;
    logic [12:0] asize;
    logic        wnr;
    logic [31:0] rsize;
    logic [3:0]  dev;
    logic [31:0] doff;
    bit          drain;  // hold this request until all results are back
  } request_t;

  typedef struct {
    status_e     status;
    logic [3:0]  device;
    logic [31:0] offset;
    logic [12:0] length;
    logic        dir;
    logic        last;
  } route_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i = '0;
  logic [31:0] address_i = '0;
  logic [12:0] access_size_i = '0;
  logic        write_not_read_i = 1'b0;
  logic [31:0] region_size_i = '0;
  logic [3:0]  device_number_i = '0;
  logic [31:0] device_base_offset_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [3:0]  target_device_o;
  logic [31:0] target_offset_o;
  logic [12:0] segment_length_o;
  logic        direction_o;
  logic        last_o;

  address_region_decoder dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  request_t pending_q[$];
  route_t   routes_q[$];
  int       errors = 0;
  int       cycles = 0;
  bit       req_taken = 1'b0;
  int       send_gap = 0;
  int       stall_left = 0;

  // Appends one expected result to the tail of the expectation queue.
  function automatic void queue_route(route_t r);
    routes_q = {routes_q, r};
  endfunction

  // Appends one request to the tail of the stimulus queue.
  function automatic void queue_request(request_t r);
    pending_q = {pending_q, r};
  endfunction

  // Local copy of the region table. Only entries whose valid bit is set are
  // ever looked at, so the other fields need no reset.
  bit          tbl_valid[REGIONS];
  logic [31:0] tbl_base[REGIONS];
  logic [32:0] tbl_end[REGIONS];
  logic [3:0]  tbl_dev[REGIONS];
  logic [31:0] tbl_off[REGIONS];

  function automatic route_t make_route(status_e st, logic [3:0] dv, logic [31:0] off,
                                        logic [12:0] len, logic dir);
    route_t r;
    r.status = st;
    r.device = dv;
    r.offset = off;
    r.length = len;
    r.dir    = dir;
    r.last   = 1'b0;
    return r;
  endfunction

  // Splits an access into segments, one per region crossed, in address order.
  // Coverage that stops at a gap or at 2^32 ends in a fault at that address.
  task automatic route_access(request_t rq);
    logic [33:0] cur;
    logic [33:0] stop;
    logic [33:0] seg_end;
    int          hit;
    int          n;
    cur  = {2'b00, rq.addr};
    stop = cur + rq.asize;
    n    = 0;
    if (rq.asize == 0 || rq.asize > MAX_BYTES) begin
      queue_route(make_route(ST_FAULT, 4'd0, rq.addr, 13'd0, rq.wnr));
      return;
    end
    while (cur < stop && n < REGIONS) begin
      hit = -1;
      for (int i = 0; i < REGIONS; i++) begin
        if (hit < 0 && tbl_valid[i] && {2'b00, tbl_base[i]} <= cur &&
            cur < {1'b0, tbl_end[i]}) begin
          hit = i;
        end
      end
      if (hit < 0) break;
      seg_end = ({1'b0, tbl_end[hit]} < stop) ? {1'b0, tbl_end[hit]} : stop;
      queue_route(make_route(ST_SEGMENT, tbl_dev[hit],
                             cur[31:0] - tbl_base[hit] + tbl_off[hit],
                             13'(seg_end - cur), rq.wnr));
      n++;
      cur = seg_end;
    end
    if (cur < stop) begin
      queue_route(make_route(ST_FAULT, 4'd0, cur[31:0], 13'd0, rq.wnr));
    end
  endtask

  // Inserts a region unless it is empty, names a missing device, overlaps
  // any existing region, or finds the table full. The end is clipped at 2^32.
  function automatic status_e table_add(request_t rq);
    logic [33:0] rend;
    int          slot;
    rend = {2'b00, rq.addr} + rq.rsize;
    slot = -1;
    if (rq.rsize == 0 || rq.dev >= DEVICES) return ST_REJECTED;
    if (rend > 34'h1_0000_0000) rend = 34'h1_0000_0000;
    for (int i = 0; i < REGIONS; i++) begin
      if (tbl_valid[i]) begin
        if ({2'b00, tbl_base[i]} < rend && {2'b00, rq.addr} < {1'b0, tbl_end[i]})
          return ST_REJECTED;
      end else if (slot < 0) begin
        slot = i;
      end
    end
    if (slot < 0) return ST_REJECTED;
    tbl_valid[slot] = 1'b1;
    tbl_base[slot]  = rq.addr;
    tbl_end[slot]   = rend[32:0];
    tbl_dev[slot]   = rq.dev;
    tbl_off[slot]   = rq.doff;
    return ST_ADDED;
  endfunction

  function automatic status_e table_remove(logic [31:0] base);
    for (int i = 0; i < REGIONS; i++) begin
      if (tbl_valid[i] && tbl_base[i] == base) begin
        tbl_valid[i] = 1'b0;
        return ST_REMOVED;
      end
    end
    return ST_NOT_FOUND;
  endfunction

  // Queues the results of one accepted request and marks the final one.
  task automatic predict_routes(request_t rq);
    int prior_count;
    prior_count = routes_q.size();
    case (rq.cmd)
      CMD_ACCESS: route_access(rq);
      CMD_ADD: queue_route(make_route(table_add(rq), 4'd0, 32'd0, 13'd0, 1'b0));
      CMD_REMOVE:
        queue_route(make_route(table_remove(rq.addr), 4'd0, 32'd0, 13'd0, 1'b0));
      default: ;
    endcase
    if (routes_q.size() > prior_count) routes_q[routes_q.size() - 1].last = 1'b1;
  endtask

  // Monitor: accepted requests feed the predictor, accepted results are
  // checked against the oldest expectation, field by field.
  always @(posedge clk_i) begin
    route_t want;
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: timeout with %0d results outstanding", $time, routes_q.size());
      $display("== FAIL ==");
      $finish;
    end
    req_taken = in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (req_taken) begin
        predict_routes('{command_i, address_i, access_size_i, write_not_read_i,
                         region_size_i, device_number_i, device_base_offset_i, 1'b0});
      end
      if (out_valid_o && out_ready_i) begin
        if (routes_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d offset=%h", $time, status_o,
                   target_offset_o);
          errors++;
        end else begin
          want = routes_q.pop_front();
          if (status_o !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
            errors++;
          end
          if (target_device_o !== want.device) begin
            $display("%0t: device expected %0d actual %0d", $time, want.device,
                     target_device_o);
            errors++;
          end
          if (target_offset_o !== want.offset) begin
            $display("%0t: offset expected %h actual %h", $time, want.offset,
                     target_offset_o);
            errors++;
          end
          if (segment_length_o !== want.length) begin
            $display("%0t: length expected %0d actual %0d", $time, want.length,
                     segment_length_o);
            errors++;
          end
          if (direction_o !== want.dir) begin
            $display("%0t: direction expected %0d actual %0d", $time, want.dir, direction_o);
            errors++;
          end
          if (last_o !== want.last) begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, last_o);
            errors++;
          end
        end
      end
    end
  end

  // Driver: offers the next pending request at the falling edge. Each signal
  // gets a single assignment per edge, so a request that follows straight on
  // from the previous one keeps valid high.
  always @(negedge clk_i) begin
    request_t rq;
    bit       hold;
    bit       calm;
    bit       ready_next;
    if (rst_ni) begin
      calm = pending_q.size() < CALM_ITEMS;
      hold = in_valid_i && !req_taken;
      if (!hold) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() == 0 ||
                     (pending_q[0].drain && routes_q.size() != 0)) begin
          in_valid_i <= 1'b0;
        end else begin
          rq = pending_q.pop_front();
          in_valid_i           <= 1'b1;
          command_i            <= rq.cmd;
          address_i            <= rq.addr;
          access_size_i        <= rq.asize;
          write_not_read_i     <= rq.wnr;
          region_size_i        <= rq.rsize;
          device_number_i      <= rq.dev;
          device_base_offset_i <= rq.doff;
          if (!calm && $urandom_range(0, 9) < 3) send_gap = $urandom_range(1, 16);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 16);
      end
      out_ready_i <= ready_next;
    end
  end

  function automatic request_t req(logic [1:0] cmd, logic [31:0] addr, logic [12:0] asize,
                                   logic wnr, logic [31:0] rsize, logic [3:0] dev,
                                   logic [31:0] doff);
    request_t r;
    r = '{cmd, addr, asize, wnr, rsize, dev, doff, 1'b0};
    return r;
  endfunction

  // Random request aimed mostly at a small window so that regions pack
  // together and accesses run across several of them.
  function automatic request_t random_req(logic [31:0] window);
    request_t r;
    int       pick;
    r = req(CMD_ACCESS, $urandom(), 13'($urandom()), 1'($urandom()), $urandom(),
            4'($urandom()), $urandom());
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      r.cmd = CMD_ACCESS;
      if ($urandom_range(0, 9) < 8) r.addr = window + $urandom_range(0, 6000);
      if ($urandom_range(0, 9) < 8) r.asize = 13'($urandom_range(1, MAX_BYTES));
    end else if (pick < 82) begin
      r.cmd = CMD_ADD;
      if ($urandom_range(0, 9) < 8) begin
        r.addr  = window + $urandom_range(0, 6000);
        r.rsize = $urandom_range(1, 1500);
      end
      if ($urandom_range(0, 19) == 0) r.rsize = 32'd0;
    end else if (pick < 96) begin
      r.cmd = CMD_REMOVE;
      if ($urandom_range(0, 9) < 7) r.addr = window + $urandom_range(0, 6000);
    end else begin
      r.cmd = CMD_UNUSED;
    end
    return r;
  endfunction

  initial begin
    logic [31:0] window;
    request_t    rq;
    // Empty table: every access faults; bad sizes fault at the address.
    queue_request(req(CMD_ACCESS, 32'h0000_0000, 13'd1, 1'b0, '0, '0, '0));
    queue_request(req(CMD_ACCESS, 32'hFFFF_FFFF, 13'd0, 1'b1, '0, '0, '0));
    queue_request(req(CMD_ACCESS, 32'h1234_5678, 13'd4097, 1'b0, '0, '0, '0));
    queue_request(req(CMD_ACCESS, 32'h0000_1000, 13'h1FFF, 1'b1, '0, '0, '0));
    // Adjacent regions, two overlaps, a zero size, and one clipped at 2^32.
    queue_request(req(CMD_ADD, 32'h0000_1000, '0, 1'b0, 32'h0000_0800, 4'd3,
                      32'h8000_0000));
    queue_request(req(CMD_ADD, 32'h0000_1800, '0, 1'b0, 32'h0000_0400, 4'd0, 32'd0));
    queue_request(req(CMD_ADD, 32'h0000_1700, '0, 1'b0, 32'h0000_0200, 4'd5, 32'd7));
    queue_request(req(CMD_ADD, 32'h0000_0F00, '0, 1'b0, 32'h0000_0200, 4'd5, 32'd7));
    queue_request(req(CMD_ADD, 32'h0001_0000, '0, 1'b0, 32'd0, 4'd1, 32'd0));
    queue_request(req(CMD_ADD, 32'hFFFF_F000, '0, 1'b1, 32'hFFFF_FFFF, 4'd15,
                      32'hFFFF_FFFF));
    // Access across two regions then a gap; access running past 2^32.
    queue_request(req(CMD_ACCESS, 32'h0000_1000, 13'd4096, 1'b1, '0, '0, '0));
    queue_request(req(CMD_ACCESS, 32'hFFFF_F800, 13'd4096, 1'b0, '0, '0, '0));
    queue_request(req(CMD_ACCESS, 32'h0000_0FFF, 13'd2, 1'b0, '0, '0, '0));
    // Fill the table, then one more add is refused.
    for (int i = 0; i < 6; i++) begin
      queue_request(req(CMD_ADD, 32'h0000_2000 + 32'(i) * 32'h100, '0, 1'b0,
                        32'h100, 4'(i + 6), 32'(i) * 32'h10));
    end
    queue_request(req(CMD_ACCESS, 32'h0000_1F80, 13'd1792, 1'b1, '0, '0, '0));
    queue_request(req(CMD_REMOVE, 32'h0000_1800, '0, 1'b0, '0, '0, '0));
    queue_request(req(CMD_REMOVE, 32'h0000_1800, '0, 1'b0, '0, '0, '0));
    queue_request(req(CMD_UNUSED, 32'h0000_1000, 13'd4, 1'b1, 32'd4, 4'd2, 32'd0));
    rq = req(CMD_ACCESS, 32'h0000_1000, 13'd4096, 1'b0, '0, '0, '0);
    rq.drain = 1'b1;
    queue_request(rq);
    // Clear the directed regions so random traffic starts from a fresh table.
    queue_request(req(CMD_REMOVE, 32'h0000_1000, '0, 1'b0, '0, '0, '0));
    queue_request(req(CMD_REMOVE, 32'hFFFF_F000, '0, 1'b0, '0, '0, '0));
    for (int i = 0; i < 6; i++) begin
      queue_request(req(CMD_REMOVE, 32'h0000_2000 + 32'(i) * 32'h100, '0, 1'b0,
                        '0, '0, '0));
    end
    window = $urandom() & 32'hFFFF_F000;
    for (int i = 0; i < 120; i++) begin
      if (i % 50 == 25) window = $urandom() & 32'hFFFF_F000;
      rq = random_req(window);
      if (i == 60 || i == 110) rq.drain = 1'b1;
      queue_request(rq);
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_q.size() == 0 && !in_valid_i && routes_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && routes_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
